### rtl/core/bmc_pkg.sv
`default_nettype none
package bmc_pkg;

  localparam int DEF_MAX_WIDTH  = 32;
  localparam int DEF_MAX_HEIGHT = 32;
  localparam int CFG_W          = 6;
  localparam logic [CFG_W-1:0] GRID_RESET = 6'd16;

  localparam logic CFG_IDX_WIDTH  = 1'b0;
  localparam logic CFG_IDX_HEIGHT = 1'b1;

  localparam logic KIND_RESTART = 1'b0;

  localparam logic [1:0] DIR_N = 2'd0;
  localparam logic [1:0] DIR_E = 2'd1;
  localparam logic [1:0] DIR_S = 2'd2;
  localparam logic [1:0] DIR_W = 2'd3;
  localparam logic [1:0] LAST_TRY = 2'd3;

  typedef enum logic [1:0] {
    ACT_CARVED  = 2'd0,
    ACT_BACK    = 2'd1,
    ACT_DONE    = 2'd2,
    ACT_RESTART = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_TOP,
    ST_MOD,
    ST_CHECK,
    ST_VIS
  } state_t;

  typedef struct packed {
    logic       load;
    logic       clr_init;
    logic       clr_step;
    logic       top_load;
    logic       chk;
    logic [1:0] k;
    logic       emit;
    action_t    act;
  } bmc_cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic clr_last;
    logic mod_done;
    logic nb_ok;
    logic vis;
  } bmc_stat_t;

endpackage
`default_nettype wire

### rtl/core/bmc_mod.sv
`default_nettype none
module bmc_mod #(
  parameter int DVD_W = 10,
  parameter int DVS_W = 6
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [DVD_W-1:0] dividend,
  input  wire logic [DVS_W-1:0] divisor,
  output logic                  done,
  output logic      [DVS_W-1:0] rem
);
  import bmc_pkg::*;

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic             run_r, run_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DVS_W-1:0] rem_r, rem_nxt;
  logic [DVD_W-1:0] sh_r, sh_nxt;
  logic [DVS_W:0]   trial;

  // restoring remainder, one dividend bit a cycle
  always_comb begin
    run_nxt  = run_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    sh_nxt   = sh_r;
    trial    = {rem_r, sh_r[DVD_W-1]};
    if (start) begin
      run_nxt = 1'b1;
      cnt_nxt = CNT_W'(DVD_W);
      rem_nxt = '0;
      sh_nxt  = dividend;
    end else if (run_r) begin
      if (trial >= {1'b0, divisor}) begin
        rem_nxt = DVS_W'(trial - {1'b0, divisor});
      end else begin
        rem_nxt = DVS_W'(trial);
      end
      sh_nxt  = {sh_r[DVD_W-2:0], 1'b0};
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    sh_r  <= sh_nxt;
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule
`default_nettype wire

### rtl/core/bmc_ctrl.sv
`default_nettype none
module bmc_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  input  wire logic                kind,
  input  wire bmc_pkg::bmc_stat_t  stat,
  output bmc_pkg::bmc_cmd_t        cmd,
  output logic                     busy
);
  import bmc_pkg::*;

  state_t     state_r, state_nxt;
  logic [1:0] k_r, k_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      k_r     <= k_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    k_nxt     = k_r;
    cmd       = '0;
    cmd.k     = k_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          if (kind == KIND_RESTART) begin
            cmd.clr_init = 1'b1;
            state_nxt    = ST_CLEAR;
          end else if (stat.empty) begin
            cmd.emit = 1'b1;
            cmd.act  = ACT_DONE;
          end else begin
            state_nxt = ST_TOP;
          end
        end
      end
      ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_last) begin
          cmd.emit  = 1'b1;
          cmd.act   = ACT_RESTART;
          state_nxt = ST_IDLE;
        end
      end
      ST_TOP: begin
        cmd.top_load = 1'b1;
        k_nxt        = '0;
        state_nxt    = ST_MOD;
      end
      ST_MOD: begin
        if (stat.mod_done) begin
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        cmd.chk = 1'b1;
        if (stat.nb_ok) begin
          state_nxt = ST_VIS;
        end else if (k_r == LAST_TRY) begin
          cmd.emit  = 1'b1;
          cmd.act   = ACT_BACK;
          state_nxt = ST_IDLE;
        end else begin
          k_nxt = k_r + 2'd1;
        end
      end
      ST_VIS: begin
        priority if (stat.vis && k_r != LAST_TRY) begin
          k_nxt     = k_r + 2'd1;
          state_nxt = ST_CHECK;
        end else if (stat.vis || stat.full) begin
          cmd.emit  = 1'b1;
          cmd.act   = ACT_BACK;
          state_nxt = ST_IDLE;
        end else begin
          cmd.emit  = 1'b1;
          cmd.act   = ACT_CARVED;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign busy = (state_r != ST_IDLE);

endmodule
`default_nettype wire

### rtl/core/bmc_dpath.sv
`default_nettype none
module bmc_dpath #(
  parameter int MAX_WIDTH  = 32,
  parameter int MAX_HEIGHT = 32
) (
  input  wire logic                                       clk,
  input  wire logic                                       rst_n,
  input  wire bmc_pkg::bmc_cmd_t                          cmd,
  output bmc_pkg::bmc_stat_t                              stat,
  input  wire logic                                       cfg_we,
  input  wire logic                                       cfg_index,
  input  wire logic [bmc_pkg::CFG_W-1:0]                  cfg_wdata,
  input  wire logic [1:0]                                 in_first_dir,
  input  wire logic [1:0]                                 in_second_dir,
  input  wire logic [1:0]                                 in_third_dir,
  input  wire logic [1:0]                                 in_fourth_dir,
  output logic                                            out_valid,
  output logic [1:0]                                      out_action,
  output logic [$clog2(MAX_WIDTH*MAX_HEIGHT)-1:0]         out_from_cell,
  output logic [$clog2(MAX_WIDTH*MAX_HEIGHT)-1:0]         out_to_cell,
  output logic [1:0]                                      out_carve_dir,
  output logic [$clog2(MAX_WIDTH*MAX_HEIGHT+1)-1:0]       out_depth
);
  import bmc_pkg::*;

  localparam int CELLS   = MAX_WIDTH * MAX_HEIGHT;
  localparam int CW      = $clog2(CELLS);
  localparam int DEPTH_W = $clog2(CELLS + 1);
  localparam int NW      = CW + 1;
  localparam int DIMW_W  = $clog2(MAX_WIDTH + 1);
  localparam int DIMH_W  = $clog2(MAX_HEIGHT + 1);

  logic [CFG_W-1:0]   grid_w_r, grid_h_r;
  logic [DIMW_W-1:0]  w_cl;
  logic [DIMH_W-1:0]  h_cl;
  logic [NW-1:0]      cells_r;

  logic [1:0]         dirs_r [4];
  logic [CW-1:0]      top_r;
  logic [NW-1:0]      nb_r;
  logic [1:0]         dir_r;
  logic [DEPTH_W-1:0] count_r, count_nxt;
  logic [CW-1:0]      clr_addr_r;

  logic               vis_mem [CELLS];
  logic               vis_q;
  logic [CW-1:0]      stk_mem [CELLS];
  logic [CW-1:0]      stk_q;

  logic               vis_we, vis_wd;
  logic [CW-1:0]      vis_wa;
  logic               stk_we;
  logic [CW-1:0]      stk_wa, stk_wd;
  logic [CW-1:0]      stk_ra;

  logic               mod_done;
  logic [DIMW_W-1:0]  col;

  logic [1:0]         dir_sel;
  logic               dir_ok;
  logic [NW-1:0]      nb, top_e, w_e;

  logic               out_valid_r;
  action_t            out_action_r;
  logic [CW-1:0]      out_from_r, out_to_r;
  logic [1:0]         out_dir_r;
  logic [DEPTH_W-1:0] out_depth_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_w_r <= GRID_RESET;
      grid_h_r <= GRID_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_IDX_WIDTH:  grid_w_r <= cfg_wdata;
        CFG_IDX_HEIGHT: grid_h_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // clamp the grid size into one to the maximum
  always_comb begin
    if (grid_w_r == '0) begin
      w_cl = DIMW_W'(1);
    end else if (32'(grid_w_r) > MAX_WIDTH) begin
      w_cl = DIMW_W'(MAX_WIDTH);
    end else begin
      w_cl = DIMW_W'(grid_w_r);
    end
    if (grid_h_r == '0) begin
      h_cl = DIMH_W'(1);
    end else if (32'(grid_h_r) > MAX_HEIGHT) begin
      h_cl = DIMH_W'(MAX_HEIGHT);
    end else begin
      h_cl = DIMH_W'(grid_h_r);
    end
  end

  always_ff @(posedge clk) begin
    cells_r <= NW'(w_cl) * NW'(h_cl);
  end

  bmc_mod #(
    .DVD_W (CW),
    .DVS_W (DIMW_W)
  ) u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.top_load),
    .dividend (stk_q),
    .divisor  (w_cl),
    .done     (mod_done),
    .rem      (col)
  );

  // neighbor of the top cell in the selected direction
  always_comb begin
    dir_sel = dirs_r[cmd.k];
    top_e   = NW'(top_r);
    w_e     = NW'(w_cl);
    unique case (dir_sel)
      DIR_N: begin
        dir_ok = (top_e >= w_e);
        nb     = top_e - w_e;
      end
      DIR_E: begin
        dir_ok = (col != w_cl - DIMW_W'(1));
        nb     = top_e + NW'(1);
      end
      DIR_S: begin
        dir_ok = 1'b1;
        nb     = top_e + w_e;
      end
      DIR_W: begin
        dir_ok = (col != '0);
        nb     = top_e - NW'(1);
      end
      default: begin
        dir_ok = 1'b0;
        nb     = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      dirs_r[0] <= in_first_dir;
      dirs_r[1] <= in_second_dir;
      dirs_r[2] <= in_third_dir;
      dirs_r[3] <= in_fourth_dir;
    end
    if (cmd.top_load) begin
      top_r <= stk_q;
    end
    if (cmd.chk) begin
      nb_r  <= nb;
      dir_r <= dir_sel;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
    end else if (cmd.clr_init) begin
      clr_addr_r <= '0;
    end else if (cmd.clr_step) begin
      clr_addr_r <= clr_addr_r + CW'(1);
    end
  end

  // memory ports; the sweep leaves only cell 0 marked
  always_comb begin
    vis_we = cmd.clr_step || (cmd.emit && cmd.act == ACT_CARVED);
    vis_wa = cmd.clr_step ? clr_addr_r : nb_r[CW-1:0];
    vis_wd = cmd.clr_step ? (clr_addr_r == '0) : 1'b1;
    stk_we = cmd.emit && (cmd.act == ACT_CARVED || cmd.act == ACT_RESTART);
    stk_wa = (cmd.act == ACT_RESTART) ? '0 : count_r[CW-1:0];
    stk_wd = (cmd.act == ACT_RESTART) ? '0 : nb_r[CW-1:0];
    stk_ra = CW'(count_r - DEPTH_W'(1));
  end

  always_ff @(posedge clk) begin
    if (vis_we) begin
      vis_mem[vis_wa] <= vis_wd;
    end
    vis_q <= vis_mem[nb[CW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (stk_we) begin
      stk_mem[stk_wa] <= stk_wd;
    end
    stk_q <= stk_mem[stk_ra];
  end

  always_comb begin
    count_nxt = count_r;
    if (cmd.emit) begin
      unique case (cmd.act)
        ACT_CARVED:  count_nxt = count_r + DEPTH_W'(1);
        ACT_BACK:    count_nxt = count_r - DEPTH_W'(1);
        ACT_DONE:    count_nxt = '0;
        ACT_RESTART: count_nxt = DEPTH_W'(1);
        default:     count_nxt = count_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // result beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit;
    end
    if (cmd.emit) begin
      out_action_r <= cmd.act;
      out_depth_r  <= count_nxt;
      if (cmd.act == ACT_CARVED || cmd.act == ACT_BACK) begin
        out_from_r <= top_r;
      end else begin
        out_from_r <= '0;
      end
      if (cmd.act == ACT_CARVED) begin
        out_to_r  <= nb_r[CW-1:0];
        out_dir_r <= dir_r;
      end else begin
        out_to_r  <= '0;
        out_dir_r <= '0;
      end
    end
  end

  always_comb begin
    stat          = '0;
    stat.empty    = (count_r == '0);
    stat.full     = (count_r == DEPTH_W'(CELLS));
    stat.clr_last = (clr_addr_r == CW'(CELLS - 1));
    stat.mod_done = mod_done;
    stat.nb_ok    = dir_ok && (nb < cells_r);
    stat.vis      = vis_q;
  end

  assign out_valid     = out_valid_r;
  assign out_action    = out_action_r;
  assign out_from_cell = out_from_r;
  assign out_to_cell   = out_to_r;
  assign out_carve_dir = out_dir_r;
  assign out_depth     = out_depth_r;

endmodule
`default_nettype wire

### rtl/core/backtracker_maze_carver_top.sv
// Restart: the result follows the visited-map sweep.
// Step on an empty stack: the result is registered in the cycle after accept.
// Step: the result waits on the bit-serial column remainder and up to four
//   visited-map reads on one memory port.
// One item at a time; each result is a one-cycle beat on out_valid, never stalled.
// Reset clears control, the stack count and sets the grid to 16 by 16.
`default_nettype none
module backtracker_maze_carver_top #(
  parameter int MAX_WIDTH  = bmc_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = bmc_pkg::DEF_MAX_HEIGHT
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  start,
  output logic                                       busy,
  input  wire logic                                  in_kind,
  input  wire logic [1:0]                            in_first_dir,
  input  wire logic [1:0]                            in_second_dir,
  input  wire logic [1:0]                            in_third_dir,
  input  wire logic [1:0]                            in_fourth_dir,
  output logic                                       out_valid,
  output logic [1:0]                                 out_action,
  output logic [$clog2(MAX_WIDTH*MAX_HEIGHT)-1:0]    out_from_cell,
  output logic [$clog2(MAX_WIDTH*MAX_HEIGHT)-1:0]    out_to_cell,
  output logic [1:0]                                 out_carve_dir,
  output logic [$clog2(MAX_WIDTH*MAX_HEIGHT+1)-1:0]  out_depth,
  input  wire logic                                  cfg_we,
  input  wire logic                                  cfg_index,
  input  wire logic [bmc_pkg::CFG_W-1:0]             cfg_wdata
);
  import bmc_pkg::*;

  bmc_cmd_t  cmd;
  bmc_stat_t stat;

  bmc_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .kind  (in_kind),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  bmc_dpath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .stat          (stat),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_first_dir  (in_first_dir),
    .in_second_dir (in_second_dir),
    .in_third_dir  (in_third_dir),
    .in_fourth_dir (in_fourth_dir),
    .out_valid     (out_valid),
    .out_action    (out_action),
    .out_from_cell (out_from_cell),
    .out_to_cell   (out_to_cell),
    .out_carve_dir (out_carve_dir),
    .out_depth     (out_depth)
  );

  a_beat_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy || start))
    else $error("result beat without an item in flight");

  a_carve_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_action == ACT_CARVED) |-> (out_to_cell != out_from_cell && out_depth >= 2))
    else $error("carve does not reach a new cell or grow the stack");

  a_done_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_action == ACT_DONE) |-> (out_depth == 0))
    else $error("finished beat with a non-empty stack");

endmodule
`default_nettype wire
